// File: design/multicore_deadline_list_scheduler_core_defines.svh
// assertion macros shared by the scheduler rtl
`ifndef MULTICORE_DEADLINE_LIST_SCHEDULER_CORE_DEFINES_SVH
`define MULTICORE_DEADLINE_LIST_SCHEDULER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define DLS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define DLS_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DLS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dls_pkg.sv
`timescale 1ns / 1ps
package dls_pkg;

  localparam int MAX_TASKS_DEF = 64;
  localparam int MAX_CORES_DEF = 8;
  localparam int KEY_W         = 17;
  localparam int DATA_W        = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SCHED  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_MISS  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_STOP  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KM_RELEASE  = 2'd0,
    KM_DEADLINE = 2'd1,
    KM_SUM      = 2'd2
  } key_mode_t;

  typedef enum logic {
    REG_NUM_CORES = 1'b0,
    REG_KEY_MODE  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_RES,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] exec;
    logic [DATA_W-1:0] rel;
    logic [DATA_W-1:0] dl;
  } task_t;

  // queue chain commands
  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } qctl_t;

  // free-slot chain commands
  typedef struct packed {
    logic push;
    logic pop;
    logic reload;
  } fctl_t;

endpackage

// File: design/dls_in_if.sv
`timescale 1ns / 1ps
interface dls_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] task_id;
  logic [15:0] exec_time;
  logic [15:0] release_time;
  logic [15:0] deadline;

  modport source (output valid, opcode, task_id, exec_time, release_time, deadline,
                  input ready);
  modport sink (input valid, opcode, task_id, exec_time, release_time, deadline,
                output ready);
endinterface

// File: design/dls_out_if.sv
`timescale 1ns / 1ps
interface dls_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] task_id_out;
  logic [2:0]  core_index;
  logic [15:0] start_tick;
  logic [2:0]  status;

  modport source (output valid, task_id_out, core_index, start_tick, status,
                  input ready);
  modport sink (input valid, task_id_out, core_index, start_tick, status,
                output ready);
endinterface

// File: design/dls_qcell.sv
`timescale 1ns / 1ps
module dls_qcell #(
  parameter int SW = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dls_pkg::qctl_t               ctl,
  input  logic [dls_pkg::KEY_W-1:0]    new_key,
  input  logic [SW-1:0]                new_slot,
  input  dls_pkg::task_t               new_task,
  input  logic                         prv_v,
  input  logic [dls_pkg::KEY_W-1:0]    prv_key,
  input  logic [SW-1:0]                prv_slot,
  input  dls_pkg::task_t               prv_task,
  input  logic                         prv_lt,
  input  logic                         nxt_v,
  input  logic [dls_pkg::KEY_W-1:0]    nxt_key,
  input  logic [SW-1:0]                nxt_slot,
  input  dls_pkg::task_t               nxt_task,
  output logic                         v,
  output logic [dls_pkg::KEY_W-1:0]    key,
  output logic [SW-1:0]                slot,
  output dls_pkg::task_t               tsk,
  output logic                         lt
);
  import dls_pkg::*;

  logic              v_r, v_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  task_t             tsk_r, tsk_nxt;

  // new entry orders before this one (or this cell is empty): lower key, then lower slot
  assign lt = !v_r || (new_key < key_r) || ((new_key == key_r) && (new_slot < slot_r));

  // insert shifts right, pop shifts left, clear empties the cell
  always_comb begin
    v_nxt    = v_r;
    key_nxt  = key_r;
    slot_nxt = slot_r;
    tsk_nxt  = tsk_r;
    if (ctl.clr) begin
      v_nxt = 1'b0;
    end else if (ctl.pop) begin
      v_nxt    = nxt_v;
      key_nxt  = nxt_key;
      slot_nxt = nxt_slot;
      tsk_nxt  = nxt_task;
    end else if (ctl.ins && lt) begin
      if (prv_lt) begin
        v_nxt    = prv_v;
        key_nxt  = prv_key;
        slot_nxt = prv_slot;
        tsk_nxt  = prv_task;
      end else begin
        v_nxt    = 1'b1;
        key_nxt  = new_key;
        slot_nxt = new_slot;
        tsk_nxt  = new_task;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    key_r  <= key_nxt;
    slot_r <= slot_nxt;
    tsk_r  <= tsk_nxt;
  end

  assign v    = v_r;
  assign key  = key_r;
  assign slot = slot_r;
  assign tsk  = tsk_r;
endmodule

// File: design/dls_fcell.sv
`timescale 1ns / 1ps
module dls_fcell #(
  parameter int SW  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dls_pkg::fctl_t ctl,
  input  logic [SW-1:0] new_idx,
  input  logic          prv_v,
  input  logic [SW-1:0] prv_idx,
  input  logic          prv_lt,
  input  logic          nxt_v,
  input  logic [SW-1:0] nxt_idx,
  output logic          v,
  output logic [SW-1:0] idx,
  output logic          lt
);
  import dls_pkg::*;

  logic          v_r, v_nxt;
  logic [SW-1:0] idx_r, idx_nxt;

  assign lt = !v_r || (new_idx < idx_r);

  // free slots stay sorted ascending, head is the lowest free slot
  always_comb begin
    v_nxt   = v_r;
    idx_nxt = idx_r;
    if (ctl.reload) begin
      v_nxt   = 1'b1;
      idx_nxt = SW'(IDX);
    end else if (ctl.pop) begin
      v_nxt   = nxt_v;
      idx_nxt = nxt_idx;
    end else if (ctl.push && lt) begin
      if (prv_lt) begin
        v_nxt   = prv_v;
        idx_nxt = prv_idx;
      end else begin
        v_nxt   = 1'b1;
        idx_nxt = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b1;
      idx_r <= SW'(IDX);
    end else begin
      v_r   <= v_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign v   = v_r;
  assign idx = idx_r;
endmodule

// File: design/multicore_deadline_list_scheduler_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// in_ch     in   valid/ready        opcode, task_id, exec_time, release_time, deadline
// out_ch    out  valid/ready        task_id_out, core_index, start_tick, status
// apb       in   psel/penable       num_cores (0x0), key_mode (0x4)
// insert and clear finish without leaving idle; a schedule holds the input while the core
// time ring rotates once to find the earliest core (S_SCAN), then S_CALC and S_RES, and once
// more to write it (S_WRITE, skipped on a miss); S_RES waits while the output register is full.
// rejected inserts and empty or stopped schedules show their result the cycle after
// the transfer. a new item is taken only in idle with the output register free or
// draining. synchronous active-low reset loads the free-slot chain with every slot.
`include "multicore_deadline_list_scheduler_core_defines.svh"
module multicore_deadline_list_scheduler_core #(
  parameter int MAX_TASKS = dls_pkg::MAX_TASKS_DEF,
  parameter int MAX_CORES = dls_pkg::MAX_CORES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dls_in_if.sink      in_ch,
  dls_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dls_pkg::*;

  localparam int SW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CIW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;

  // configuration registers
  logic [3:0] num_cores_r;
  logic [1:0] key_mode_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cores_r <= 4'd4;
      key_mode_r  <= KM_RELEASE;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_NUM_CORES: num_cores_r <= pwdata[3:0];
        REG_KEY_MODE:  key_mode_r  <= pwdata[1:0];
        default:       num_cores_r <= num_cores_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_NUM_CORES: prdata = {28'd0, num_cores_r};
      REG_KEY_MODE:  prdata = {30'd0, key_mode_r};
      default:       prdata = 32'd0;
    endcase
  end

  // cores in use, clamped
  logic [7:0] nc_eff;
  always_comb begin
    if (num_cores_r == 4'd0) begin
      nc_eff = 8'd1;
    end else if (8'(num_cores_r) > 8'(MAX_CORES)) begin
      nc_eff = 8'(MAX_CORES);
    end else begin
      nc_eff = 8'(num_cores_r);
    end
  end

  // control registers
  state_t             state_r, state_nxt;
  logic [CIW-1:0]     cnt_r, cnt_nxt;
  logic [CIW-1:0]     best_r, best_nxt;
  logic [DATA_W-1:0]  best_t_r, best_t_nxt;
  task_t              cur_r, cur_nxt;
  logic [DATA_W-1:0]  start_r, start_nxt;
  logic [DATA_W-1:0]  fin_r, fin_nxt;
  logic               miss_r, miss_nxt;
  logic               stopped_r, stopped_nxt;
  logic               out_v_r, out_v_nxt;
  logic [DATA_W-1:0]  out_id_r, out_id_nxt;
  logic [2:0]         out_core_r, out_core_nxt;
  logic [DATA_W-1:0]  out_start_r, out_start_nxt;
  status_t            out_st_r, out_st_nxt;
  logic [DATA_W-1:0]  ring_r [MAX_CORES];
  logic [DATA_W-1:0]  ring_nxt [MAX_CORES];

  qctl_t qctl;
  fctl_t fctl;

  // queue chain signals
  logic              q_v    [MAX_TASKS];
  logic [KEY_W-1:0]  q_key  [MAX_TASKS];
  logic [SW-1:0]     q_slot [MAX_TASKS];
  task_t             q_task [MAX_TASKS];
  logic              q_lt   [MAX_TASKS];
  logic [MAX_TASKS-1:0] q_vvec;

  // free chain signals
  logic              f_v   [MAX_TASKS];
  logic [SW-1:0]     f_idx [MAX_TASKS];
  logic              f_lt  [MAX_TASKS];
  logic [MAX_TASKS-1:0] f_vvec;

  logic [KEY_W-1:0]  new_key;
  task_t             new_task;
  logic [SW-1:0]     f_new;

  assign new_task = '{id: in_ch.task_id, exec: in_ch.exec_time,
                      rel: in_ch.release_time, dl: in_ch.deadline};
  assign f_new    = q_slot[0];

  // priority key
  always_comb begin
    case (key_mode_t'(key_mode_r))
      KM_DEADLINE: new_key = KEY_W'(in_ch.deadline);
      KM_SUM:      new_key = KEY_W'(in_ch.release_time) + KEY_W'(in_ch.deadline);
      default:     new_key = KEY_W'(in_ch.release_time);
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_chain
      logic              pv, plt, nv, fpv, fplt, fnv;
      logic [KEY_W-1:0]  pk, nk;
      logic [SW-1:0]     ps, ns, fpi, fni;
      task_t             pt, nt;
      if (gi == 0) begin : g_first
        assign pv = 1'b0;  assign plt = 1'b0;  assign pk = '0;
        assign ps = '0;    assign pt = '0;
        assign fpv = 1'b0; assign fplt = 1'b0; assign fpi = '0;
      end else begin : g_mid
        assign pv = q_v[gi-1];   assign plt = q_lt[gi-1]; assign pk = q_key[gi-1];
        assign ps = q_slot[gi-1]; assign pt = q_task[gi-1];
        assign fpv = f_v[gi-1];  assign fplt = f_lt[gi-1]; assign fpi = f_idx[gi-1];
      end
      if (gi == MAX_TASKS-1) begin : g_last
        assign nv = 1'b0;  assign nk = '0; assign ns = '0; assign nt = '0;
        assign fnv = 1'b0; assign fni = '0;
      end else begin : g_inner
        assign nv = q_v[gi+1];   assign nk = q_key[gi+1];
        assign ns = q_slot[gi+1]; assign nt = q_task[gi+1];
        assign fnv = f_v[gi+1];  assign fni = f_idx[gi+1];
      end

      dls_qcell #(.SW(SW)) u_qcell (
        .clk(clk), .rst_n(rst_n), .ctl(qctl),
        .new_key(new_key), .new_slot(f_idx[0]), .new_task(new_task),
        .prv_v(pv), .prv_key(pk), .prv_slot(ps), .prv_task(pt), .prv_lt(plt),
        .nxt_v(nv), .nxt_key(nk), .nxt_slot(ns), .nxt_task(nt),
        .v(q_v[gi]), .key(q_key[gi]), .slot(q_slot[gi]), .tsk(q_task[gi]),
        .lt(q_lt[gi])
      );

      dls_fcell #(.SW(SW), .IDX(gi)) u_fcell (
        .clk(clk), .rst_n(rst_n), .ctl(fctl), .new_idx(f_new),
        .prv_v(fpv), .prv_idx(fpi), .prv_lt(fplt),
        .nxt_v(fnv), .nxt_idx(fni),
        .v(f_v[gi]), .idx(f_idx[gi]), .lt(f_lt[gi])
      );

      assign q_vvec[gi] = q_v[gi];
      assign f_vvec[gi] = f_v[gi];
    end
  endgenerate

  logic q_full, q_empty, out_free, in_xfer, cnt_last;
  logic [DATA_W:0] fin_w;
  logic [DATA_W-1:0] start_w;
  logic [7:0] best_ext;

  assign q_full   = q_v[MAX_TASKS-1];
  assign q_empty  = !q_v[0];
  assign out_free = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cnt_last = (cnt_r == CIW'(MAX_CORES-1));
  assign start_w  = (best_t_r > cur_r.rel) ? best_t_r : cur_r.rel;
  assign fin_w    = (DATA_W+1)'(start_w) + (DATA_W+1)'(cur_r.exec);
  assign best_ext = 8'(best_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    best_t_nxt    = best_t_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    fin_nxt       = fin_r;
    miss_nxt      = miss_r;
    stopped_nxt   = stopped_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_id_nxt    = out_id_r;
    out_core_nxt  = out_core_r;
    out_start_nxt = out_start_r;
    out_st_nxt    = out_st_r;
    qctl          = '0;
    fctl          = '0;
    for (int i = 0; i < MAX_CORES; i++) begin
      ring_nxt[i] = ring_r[i];
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (op_t'(in_ch.opcode))
            OP_INSERT: begin
              if (q_full) begin
                out_v_nxt     = 1'b1;
                out_id_nxt    = in_ch.task_id;
                out_core_nxt  = 3'd0;
                out_start_nxt = '0;
                out_st_nxt    = ST_FULL;
              end else begin
                qctl.ins = 1'b1;
                fctl.pop = 1'b1;
              end
            end
            OP_SCHED: begin
              if (stopped_r || q_empty) begin
                out_v_nxt     = 1'b1;
                out_id_nxt    = '0;
                out_core_nxt  = 3'd0;
                out_start_nxt = '0;
                out_st_nxt    = stopped_r ? ST_STOP : ST_EMPTY;
              end else begin
                cur_nxt   = q_task[0];
                qctl.pop  = 1'b1;
                fctl.push = 1'b1;
                cnt_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: begin
              qctl.clr    = 1'b1;
              fctl.reload = 1'b1;
              stopped_nxt = 1'b0;
              for (int i = 0; i < MAX_CORES; i++) begin
                ring_nxt[i] = '0;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      // rotate the ring once, head is core cnt
      S_SCAN: begin
        for (int i = 0; i < MAX_CORES-1; i++) begin
          ring_nxt[i] = ring_r[i+1];
        end
        ring_nxt[MAX_CORES-1] = ring_r[0];
        if ((cnt_r == '0) || ((8'(cnt_r) < nc_eff) && (ring_r[0] < best_t_r))) begin
          best_nxt   = cnt_r;
          best_t_nxt = ring_r[0];
        end
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_CALC;
        end else begin
          cnt_nxt = cnt_r + CIW'(1);
        end
      end
      S_CALC: begin
        start_nxt = start_w;
        fin_nxt   = fin_w[DATA_W-1:0];
        miss_nxt  = fin_w > (DATA_W+1)'(cur_r.dl);
        state_nxt = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          out_v_nxt     = 1'b1;
          out_id_nxt    = cur_r.id;
          out_core_nxt  = best_ext[2:0];
          out_start_nxt = start_r;
          out_st_nxt    = miss_r ? ST_MISS : ST_OK;
          if (miss_r) begin
            stopped_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_WRITE;
          end
        end
      end
      // second rotation drops the finish time into the chosen core
      S_WRITE: begin
        for (int i = 0; i < MAX_CORES-1; i++) begin
          ring_nxt[i] = ring_r[i+1];
        end
        ring_nxt[MAX_CORES-1] = (cnt_r == best_r) ? fin_r : ring_r[0];
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CIW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      stopped_r <= 1'b0;
      out_v_r   <= 1'b0;
      for (int i = 0; i < MAX_CORES; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      stopped_r <= stopped_nxt;
      out_v_r   <= out_v_nxt;
      for (int i = 0; i < MAX_CORES; i++) begin
        ring_r[i] <= ring_nxt[i];
      end
    end
    best_r      <= best_nxt;
    best_t_r    <= best_t_nxt;
    cur_r       <= cur_nxt;
    start_r     <= start_nxt;
    fin_r       <= fin_nxt;
    miss_r      <= miss_nxt;
    out_id_r    <= out_id_nxt;
    out_core_r  <= out_core_nxt;
    out_start_r <= out_start_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.task_id_out = out_id_r;
  assign out_ch.core_index  = out_core_r;
  assign out_ch.start_tick  = out_start_r;
  assign out_ch.status      = out_st_r;

  // queue entries always fill a prefix of the chain
  `DLS_CHECK(a_q_prefix, (q_vvec & (q_vvec + MAX_TASKS'(1))) == '0, "queue has a hole")
  // every slot is either queued or free
  `DLS_CHECK(a_slot_cons, ($countones(q_vvec) + $countones(f_vvec)) == MAX_TASKS,
             "slot accounting broken")
  // chosen core lies within the cores in use
  `DLS_IMPLIES(a_core_range, state_r == S_CALC, 8'(best_r) < nc_eff, "core out of range")
  // a reported miss stops the block
  `DLS_NEXT(a_miss_stop, (state_r == S_RES) && out_free && miss_r, stopped_r,
            "miss did not stop")
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import dls_pkg::*;

  localparam int TASK_SLOTS = 64;
  localparam int CORE_SLOTS = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS = 215;

  typedef struct packed {
    logic [15:0] task_id;
    logic [2:0]  core;
    logic [15:0] start;
    status_t     status;
  } sched_res_t;

  typedef struct {
    op_t         op;
    logic [15:0] id;
    logic [15:0] ex;
    logic [15:0] rel;
    logic [15:0] dl;
    bit          typed;
    sched_res_t  res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dls_in_if in_ch ();
  dls_out_if out_ch ();

  multicore_deadline_list_scheduler_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // scheduler shadow state
  logic [16:0] q_key [TASK_SLOTS];
  logic [15:0] q_id [TASK_SLOTS];
  logic [15:0] q_ex [TASK_SLOTS];
  logic [15:0] q_rel [TASK_SLOTS];
  logic [15:0] q_dl [TASK_SLOTS];
  bit q_busy [TASK_SLOTS];
  logic [15:0] core_free [CORE_SLOTS];
  bit halted;
  logic [3:0] cores_cfg;
  logic [1:0] mode_cfg;

  sched_res_t pending_res [$];
  bit typed_next;
  sched_res_t typed_res;
  int errs = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  // compute the outcome of one transfer and update the shadow state
  function automatic bit schedule_model(input op_t op, input logic [15:0] id,
                                        input logic [15:0] ex, input logic [15:0] rel,
                                        input logic [15:0] dl, output sched_res_t r);
    int pick;
    int slot;
    int ncores;
    int core;
    logic [16:0] start;
    logic [16:0] fin;
    r = '{16'd0, 3'd0, 16'd0, ST_OK};
    case (op)
      OP_INSERT: begin
        slot = -1;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) if (!q_busy[i]) slot = i;
        if (slot < 0) begin
          r = '{id, 3'd0, 16'd0, ST_FULL};
          return 1'b1;
        end
        case (mode_cfg)
          KM_DEADLINE: q_key[slot] = {1'b0, dl};
          KM_SUM:      q_key[slot] = {1'b0, rel} + {1'b0, dl};
          default:     q_key[slot] = {1'b0, rel};
        endcase
        q_id[slot] = id;
        q_ex[slot] = ex;
        q_rel[slot] = rel;
        q_dl[slot] = dl;
        q_busy[slot] = 1'b1;
        return 1'b0;
      end
      OP_SCHED: begin
        if (halted) begin
          r.status = ST_STOP;
          return 1'b1;
        end
        pick = -1;
        for (int i = 0; i < TASK_SLOTS; i++)
          if (q_busy[i] && (pick < 0 || q_key[i] < q_key[pick])) pick = i;
        if (pick < 0) begin
          r.status = ST_EMPTY;
          return 1'b1;
        end
        ncores = (cores_cfg == 0) ? 1 : (cores_cfg > CORE_SLOTS) ? CORE_SLOTS : cores_cfg;
        core = 0;
        for (int c = 1; c < ncores; c++) if (core_free[c] < core_free[core]) core = c;
        q_busy[pick] = 1'b0;
        start = {1'b0, q_rel[pick]};
        if (core_free[core] > q_rel[pick]) start = {1'b0, core_free[core]};
        fin = start + {1'b0, q_ex[pick]};
        r = '{q_id[pick], core[2:0], start[15:0], ST_OK};
        if (fin > {1'b0, q_dl[pick]}) begin
          halted = 1'b1;
          r.status = ST_MISS;
        end else begin
          core_free[core] = fin[15:0];
        end
        return 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < TASK_SLOTS; i++) q_busy[i] = 1'b0;
        for (int c = 0; c < CORE_SLOTS; c++) core_free[c] = '0;
        halted = 1'b0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // accept transfers, check results, watch for a hang
  always @(posedge clk) begin : scoreboard
    sched_res_t r;
    sched_res_t want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        if (schedule_model(op_t'(in_ch.opcode), in_ch.task_id, in_ch.exec_time,
                           in_ch.release_time, in_ch.deadline, r))
          pending_res.push_back(typed_next ? typed_res : r);
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        r = '{out_ch.task_id_out, out_ch.core_index, out_ch.start_tick,
              status_t'(out_ch.status)};
        if (pending_res.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected result: %p", r);
        end else begin
          want = pending_res.pop_front();
          if (r.task_id !== want.task_id || r.core !== want.core ||
              r.start !== want.start || r.status !== want.status) begin
            errs++;
            if (errs <= 10) $display("mismatch: expected %p, got %p", want, r);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side ready with random stalls and a long hold whenever one is requested
  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 70) out_ch.ready <= 1'b1;
        else begin
          out_ch.ready <= 1'b0;
          repeat ((n < 96) ? $urandom_range(0, 2) : $urandom_range(20, 60)) @(negedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send(input op_t op, input logic [15:0] id, input logic [15:0] ex,
                      input logic [15:0] rel, input logic [15:0] dl);
    int n;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.task_id <= id;
    in_ch.exec_time <= ex;
    in_ch.release_time <= rel;
    in_ch.deadline <= dl;
    do @(posedge clk); while (!in_ch.ready);
    n = $urandom_range(0, 99);
    if (n >= 75) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ((n < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40)) @(negedge clk);
      typed_next = 1'b0;
    end
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_NUM_CORES) cores_cfg = val[3:0];
    else mode_cfg = val[1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one random item (insert, schedule, clear or an unused opcode), mostly feasible with some fully random fields
  task automatic random_item(input int insert_pct);
    int n;
    logic [15:0] ex;
    logic [15:0] rel;
    logic [16:0] dl;
    op_t op;
    n = $urandom_range(0, 99);
    if (halted && $urandom_range(0, 3) == 0) op = OP_CLEAR;
    else if (n < insert_pct) op = OP_INSERT;
    else if (n < 95) op = OP_SCHED;
    else if (n < 98) op = OP_CLEAR;
    else op = op_t'(2'd3);
    if ($urandom_range(0, 9) == 0) begin
      ex = 16'($urandom);
      rel = 16'($urandom);
      dl = 17'($urandom_range(0, 65535));
    end else begin
      ex = 16'($urandom_range(0, 200));
      rel = 16'($urandom_range(0, 2000));
      dl = {1'b0, rel} + {1'b0, ex} + 17'($urandom_range(0, 3000));
      if (dl > 17'hffff) dl = 17'hffff;
    end
    send(op, 16'($urandom), ex, rel, dl[15:0]);
  endtask

  stim_row_t directed [] = '{
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'h0000, 3'd0, 16'h0000, ST_EMPTY}},
    '{OP_INSERT, 16'hffff, 16'h0000, 16'hffff, 16'hffff, 0, '0},
    '{OP_INSERT, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 0, '0},
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'h0000, 3'd0, 16'h0000, ST_OK}},
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'hffff, 3'd1, 16'hffff, ST_OK}},
    '{OP_INSERT, 16'h1234, 16'h000a, 16'h0000, 16'h0005, 0, '0},
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'h1234, 3'd2, 16'h0000, ST_MISS}},
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'h0000, 3'd0, 16'h0000, ST_STOP}},
    '{OP_INSERT, 16'h0005, 16'h0001, 16'h0001, 16'h0001, 0, '0},
    '{op_t'(2'd3), 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, '0},
    '{OP_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, '0},
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'h0000, 3'd0, 16'h0000, ST_EMPTY}},
    '{OP_INSERT, 16'h0007, 16'h0003, 16'h0010, 16'h0020, 0, '0},
    '{OP_INSERT, 16'h0008, 16'h0003, 16'h0010, 16'h0020, 0, '0},
    '{OP_INSERT, 16'h0009, 16'h0002, 16'h0008, 16'h0030, 0, '0},
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, '0},
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, '0},
    '{OP_SCHED,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, '0},
    '{OP_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, '0}
  };

  // register settings per phase, extremes included
  int phase_cores [8] = '{1, 8, 0, 15, 2, 5, 8, 3};
  int phase_mode [8] = '{0, 1, 2, 3, 1, 2, 0, 2};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_INSERT;
    in_ch.task_id = '0;
    in_ch.exec_time = '0;
    in_ch.release_time = '0;
    in_ch.deadline = '0;
    for (int i = 0; i < TASK_SLOTS; i++) q_busy[i] = 1'b0;
    for (int c = 0; c < CORE_SLOTS; c++) core_free[c] = '0;
    halted = 1'b0;
    cores_cfg = 4'd4;
    mode_cfg = KM_RELEASE;
    typed_next = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, rows with typed results override the model's answer
    foreach (directed[k]) begin
      typed_next = directed[k].typed;
      typed_res = directed[k].res;
      send(directed[k].op, directed[k].id, directed[k].ex, directed[k].rel, directed[k].dl);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      typed_next = 1'b0;
    end

    // fill past capacity while the result side holds off
    hold_req = 1'b1;
    for (int i = 0; i < TASK_SLOTS + 2; i++)
      send(OP_INSERT, 16'($urandom), 16'($urandom_range(0, 50)),
           16'($urandom_range(0, 500)), 16'hffff);
    for (int i = 0; i < TASK_SLOTS + 3; i++) send(OP_SCHED, '0, '0, '0, '0);
    drain();

    // random phases under varied register settings
    for (int p = 0; p < 8; p++) begin
      reg_write(REG_NUM_CORES, phase_cores[p]);
      reg_write(REG_KEY_MODE, phase_mode[p]);
      if (p == 4) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) random_item((p % 2) ? 75 : 50);
      drain();
    end

    if (errs == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
